### rtl/kwsm_pkg.sv
`default_nettype none
package kwsm_pkg;

   localparam int LISTS_DEF = 8;
   localparam int DEPTH_DEF = 64;

   localparam int VALUE_W  = 32;
   localparam int FUNC_W   = 2;
   localparam int SEL_W    = 3;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 4;
   localparam int REQ_USER_W = FUNC_W + SEL_W;
   localparam int RSP_USER_W = SEL_W + STATUS_W;

   localparam logic [CFG_W-1:0] CFG_LISTS_RESET = 4'd8;

   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic load_item;
      logic ptr_rd;
      logic ptr_rd_scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              scan_last;
      logic              rsp_busy;
   } sts_type;

endpackage
`default_nettype wire

### rtl/k_way_sorted_merge_core.sv
// K-way merge of sorted lists.
// req channel: one beat per operation. tuser carries func (append, pop, clear)
// and the list select; tdata carries the signed value for an append.
// rsp channel: exactly one beat per request, with the popped value in tdata and
// source list plus status (ok, append dropped, pop empty) in tuser.
// csr channel: writes the number of lists in use; always ready, write it only
// while no request is in flight.
// Requests are handled one at a time. An append, clear or unused code goes
// from decode straight to commit; a pop scans the N lists in use (clamped to
// 1..LISTS), then drains the pipeline before commit.
// A pop reads one list head per cycle from the single
// element memory, pipelined through pointer read, element read and compare.
// req_tready drops after a beat and returns in the cycle the response appears,
// so the next request can be taken on the edge of the response beat.
// A stalled response holds the block in its final step, so at most one
// request waits behind it.
// Reset empties every list (per-list valid bits, no clearing pass) and sets
// the list count to 8; element memory contents are not cleared.
`default_nettype none
module k_way_sorted_merge_core #(
   parameter int LISTS = kwsm_pkg::LISTS_DEF,
   parameter int DEPTH = kwsm_pkg::DEPTH_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire [kwsm_pkg::VALUE_W-1:0]      req_tdata,   // value_in
   input  wire [kwsm_pkg::REQ_USER_W-1:0]   req_tuser,   // func, list_select
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [kwsm_pkg::VALUE_W-1:0]     rsp_tdata,   // value_out
   output logic [kwsm_pkg::RSP_USER_W-1:0]  rsp_tuser,   // source_list, status
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [kwsm_pkg::CFG_W-1:0]        csr_data     // lists_in_use
);

   kwsm_pkg::cmd_type cmd;
   kwsm_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   kwsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   kwsm_dp #(
      .LISTS (LISTS),
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

### rtl/kwsm_ctrl.sv
`default_nettype none
module kwsm_ctrl (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   input  kwsm_pkg::sts_type  sts,
   output kwsm_pkg::cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DRN1   = 3'd3;
   localparam logic [2:0] ST_DRN2   = 3'd4;
   localparam logic [2:0] ST_COMMIT = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.load_item   = req_tvalid && req_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (sts.func)
               kwsm_pkg::FUNC_APPEND: begin
                  cmd.ptr_rd = 1'b1;
                  state_in   = ST_COMMIT;
               end
               kwsm_pkg::FUNC_POP: begin
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_COMMIT;
               end
            endcase
         end
         ST_SCAN: begin
            cmd.ptr_rd      = 1'b1;
            cmd.ptr_rd_scan = 1'b1;
            if (sts.scan_last) state_in = ST_DRN1;
         end
         ST_DRN1: state_in = ST_DRN2;
         ST_DRN2: state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (!sts.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### rtl/kwsm_dp.sv
`default_nettype none
module kwsm_dp #(
   parameter int LISTS = kwsm_pkg::LISTS_DEF,
   parameter int DEPTH = kwsm_pkg::DEPTH_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  kwsm_pkg::cmd_type                   cmd,
   output kwsm_pkg::sts_type                   sts,
   input  wire [kwsm_pkg::REQ_USER_W-1:0]      req_tuser,
   input  wire [kwsm_pkg::VALUE_W-1:0]         req_tdata,
   input  wire                                 csr_valid,
   input  wire [kwsm_pkg::CFG_W-1:0]           csr_data,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [kwsm_pkg::VALUE_W-1:0]        rsp_tdata,
   output logic [kwsm_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   localparam int LW = (LISTS > 1) ? $clog2(LISTS) : 1;
   localparam int NW = $clog2(LISTS + 1);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int OW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int AW = (LISTS * DEPTH > 1) ? $clog2(LISTS * DEPTH) : 1;
   localparam int VW = kwsm_pkg::VALUE_W;
   localparam int SW = kwsm_pkg::SEL_W;
   localparam int FW = kwsm_pkg::FUNC_W;
   localparam int TW = kwsm_pkg::STATUS_W;

   logic [VW-1:0]   store_mem [LISTS*DEPTH];
   logic [2*CW-1:0] ptr_mem   [LISTS];
   logic [LISTS-1:0] ptr_valid_ff;

   logic [kwsm_pkg::CFG_W-1:0] cfg_lists_ff;
   logic [NW-1:0] n_lists;

   logic [FW-1:0] func_ff;
   logic [SW-1:0] sel_ff;
   logic [VW-1:0] value_ff;

   logic [NW-1:0] scan_cnt_ff;
   logic [LW-1:0] rd_idx;

   logic [2*CW-1:0] ptr_q_ff;
   logic            ptr_hit_ff;
   logic            s1_vld_ff;
   logic [LW-1:0]   s1_idx_ff;
   logic [AW-1:0]   s1_base_ff;
   logic [CW-1:0]   s1_head, s1_tail;

   logic            s2_vld_ff;
   logic [LW-1:0]   s2_idx_ff;
   logic [CW-1:0]   s2_head_ff, s2_tail_ff;
   logic [VW-1:0]   store_q_ff;

   logic            found_ff;
   logic [LW-1:0]   best_idx_ff;
   logic [CW-1:0]   best_head_ff, best_tail_ff;
   logic [VW-1:0]   best_val_ff;

   logic            sel_ok, app_full;
   logic            store_we, ptr_we, ptr_clr;
   logic [LW-1:0]   ptr_wr_idx;
   logic [2*CW-1:0] ptr_wr_data;
   logic [VW-1:0]   res_val;
   logic [SW-1:0]   res_src;
   logic [TW-1:0]   res_status;

   logic            rsp_valid_ff;
   logic [VW-1:0]   rsp_val_ff;
   logic [SW-1:0]   rsp_src_ff;
   logic [TW-1:0]   rsp_status_ff;

   // active list count clamped to 1..LISTS
   always_comb begin
      if (cfg_lists_ff == '0) begin
         n_lists = NW'(1);
      end else if (32'(cfg_lists_ff) > LISTS) begin
         n_lists = NW'(LISTS);
      end else begin
         n_lists = NW'(cfg_lists_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_lists_ff <= kwsm_pkg::CFG_LISTS_RESET;
      end else if (csr_valid) begin
         cfg_lists_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff  <= req_tuser[FW-1:0];
         sel_ff   <= req_tuser[FW+SW-1:FW];
         value_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
      end else if (cmd.load_item) begin
         scan_cnt_ff <= '0;
      end else if (cmd.ptr_rd && cmd.ptr_rd_scan) begin
         scan_cnt_ff <= scan_cnt_ff + NW'(1);
      end
   end

   assign rd_idx = cmd.ptr_rd_scan ? scan_cnt_ff[LW-1:0] : LW'(sel_ff);

   // stage 1: pointer read
   always_ff @(posedge clock) begin
      if (cmd.ptr_rd) begin
         ptr_q_ff   <= ptr_mem[rd_idx];
         ptr_hit_ff <= ptr_valid_ff[rd_idx];
         s1_idx_ff  <= rd_idx;
         s1_base_ff <= AW'(32'(rd_idx) * DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.ptr_rd && cmd.ptr_rd_scan;
         s2_vld_ff <= s1_vld_ff && (s1_head < s1_tail);
      end
   end

   assign s1_head = ptr_hit_ff ? ptr_q_ff[2*CW-1:CW] : '0;
   assign s1_tail = ptr_hit_ff ? ptr_q_ff[CW-1:0]    : '0;

   // stage 2: element read at list head
   always_ff @(posedge clock) begin
      store_q_ff <= store_mem[s1_base_ff + AW'(s1_head[OW-1:0])];
      s2_idx_ff  <= s1_idx_ff;
      s2_head_ff <= s1_head;
      s2_tail_ff <= s1_tail;
   end

   // stage 3: running minimum, later list wins ties
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.load_item) begin
         found_ff <= 1'b0;
      end else if (s2_vld_ff) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_vld_ff && (!found_ff || ($signed(store_q_ff) <= $signed(best_val_ff)))) begin
         best_idx_ff  <= s2_idx_ff;
         best_head_ff <= s2_head_ff;
         best_tail_ff <= s2_tail_ff;
         best_val_ff  <= store_q_ff;
      end
   end

   assign sel_ok   = 32'(sel_ff) < LISTS;
   assign app_full = !sel_ok || (s1_tail >= CW'(DEPTH));

   always_comb begin
      store_we    = 1'b0;
      ptr_we      = 1'b0;
      ptr_clr     = 1'b0;
      ptr_wr_idx  = s1_idx_ff;
      ptr_wr_data = {s1_head, s1_tail + CW'(1)};
      res_val     = '0;
      res_src     = '0;
      res_status  = kwsm_pkg::STATUS_OK;
      case (func_ff)
         kwsm_pkg::FUNC_APPEND: begin
            if (app_full) begin
               res_status = kwsm_pkg::STATUS_FULL;
            end else begin
               store_we = cmd.commit;
               ptr_we   = cmd.commit;
            end
         end
         kwsm_pkg::FUNC_POP: begin
            if (found_ff) begin
               ptr_we      = cmd.commit;
               ptr_wr_idx  = best_idx_ff;
               ptr_wr_data = {best_head_ff + CW'(1), best_tail_ff};
               res_val     = best_val_ff;
               res_src     = SW'(best_idx_ff);
            end else begin
               res_status = kwsm_pkg::STATUS_EMPTY;
            end
         end
         kwsm_pkg::FUNC_CLEAR: begin
            ptr_clr = cmd.commit;
         end
         default: begin
            res_status = kwsm_pkg::STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[s1_base_ff + AW'(s1_tail[OW-1:0])] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ptr_we) begin
         ptr_mem[ptr_wr_idx] <= ptr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ptr_clr) begin
         ptr_valid_ff <= '0;
      end else if (ptr_we) begin
         ptr_valid_ff[ptr_wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_val_ff    <= res_val;
         rsp_src_ff    <= res_src;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_val_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_src_ff};

   assign sts.func      = func_ff;
   assign sts.scan_last = (scan_cnt_ff == n_lists - NW'(1));
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_tready;

endmodule
`default_nettype wire

### rtl/kwsm_checker.sv
`default_nettype none
module kwsm_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [kwsm_pkg::VALUE_W-1:0]      rsp_tdata,
   input wire [kwsm_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   localparam int SW = kwsm_pkg::SEL_W;
   localparam int UW = kwsm_pkg::RSP_USER_W;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[UW-1:SW] != kwsm_pkg::STATUS_OK)
         |-> (rsp_tdata == '0) && (rsp_tuser[SW-1:0] == '0))
      else $error("failed operation carries nonzero payload");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[UW-1:SW] == kwsm_pkg::STATUS_OK)
                  || (rsp_tuser[UW-1:SW] == kwsm_pkg::STATUS_FULL)
                  || (rsp_tuser[UW-1:SW] == kwsm_pkg::STATUS_EMPTY))
      else $error("undefined status code");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind k_way_sorted_merge_core kwsm_checker u_kwsm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

### verif/k_way_sorted_merge_core_checker.sv
`timescale 1ns / 1ps
module k_way_sorted_merge_core_checker #(
   parameter int LISTS = kwsm_pkg::LISTS_DEF,
   parameter int DEPTH = kwsm_pkg::DEPTH_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   input  wire                                req_tready,
   input  wire [kwsm_pkg::VALUE_W-1:0]        req_tdata,   // value_in
   input  wire [kwsm_pkg::REQ_USER_W-1:0]     req_tuser,   // func, list_select
   input  wire                                rsp_tvalid,
   input  wire                                rsp_tready,
   input  wire [kwsm_pkg::VALUE_W-1:0]        rsp_tdata,   // value_out
   input  wire [kwsm_pkg::RSP_USER_W-1:0]     rsp_tuser,   // source_list, status
   input  wire                                csr_valid,
   input  wire                                csr_ready,
   input  wire [kwsm_pkg::CFG_W-1:0]          csr_data,    // lists_in_use
   output int                                 mismatches,
   output int                                 outstanding
);

   typedef struct packed {
      logic [kwsm_pkg::VALUE_W-1:0]  value;
      logic [kwsm_pkg::SEL_W-1:0]    source;
      logic [kwsm_pkg::STATUS_W-1:0] status;
   } merge_result_type;

   logic [kwsm_pkg::VALUE_W-1:0] list_mem [LISTS][DEPTH];
   int unsigned                  head_ptr [LISTS];
   int unsigned                  tail_ptr [LISTS];
   logic [kwsm_pkg::CFG_W-1:0]   lists_cfg;
   merge_result_type             results_due [$];

   function automatic merge_result_type merge_step(
         input logic [kwsm_pkg::FUNC_W-1:0]  op,
         input logic [kwsm_pkg::SEL_W-1:0]   sel,
         input logic [kwsm_pkg::VALUE_W-1:0] val);
      merge_result_type r;
      int               n;
      int               best;
      logic             found;
      r = '0;
      case (op)
         kwsm_pkg::FUNC_APPEND: begin
            if (sel >= LISTS || tail_ptr[sel] >= DEPTH) begin
               r.status = kwsm_pkg::STATUS_FULL;
            end else begin
               list_mem[sel][tail_ptr[sel]] = val;
               tail_ptr[sel]++;
            end
         end
         kwsm_pkg::FUNC_POP: begin
            n = (lists_cfg == 0) ? 1 : ((lists_cfg > LISTS) ? LISTS : int'(lists_cfg));
            found = 1'b0;
            best = 0;
            for (int i = 0; i < n; i++) begin
               // ties go to the higher list
               if (head_ptr[i] < tail_ptr[i] &&
                   (!found || $signed(list_mem[i][head_ptr[i]]) <=
                              $signed(list_mem[best][head_ptr[best]]))) begin
                  best = i;
                  found = 1'b1;
               end
            end
            if (found) begin
               r.value = list_mem[best][head_ptr[best]];
               r.source = kwsm_pkg::SEL_W'(best);
               head_ptr[best]++;
            end else begin
               r.status = kwsm_pkg::STATUS_EMPTY;
            end
         end
         kwsm_pkg::FUNC_CLEAR: begin
            for (int i = 0; i < LISTS; i++) begin
               head_ptr[i] = 0;
               tail_ptr[i] = 0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      merge_result_type seen;
      merge_result_type due;
      if (reset) begin
         for (int i = 0; i < LISTS; i++) begin
            head_ptr[i] = 0;
            tail_ptr[i] = 0;
         end
         lists_cfg = kwsm_pkg::CFG_LISTS_RESET;
         results_due.delete();
         mismatches = 0;
         outstanding = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.value = rsp_tdata;
            seen.source = rsp_tuser[kwsm_pkg::SEL_W-1:0];
            seen.status = rsp_tuser[kwsm_pkg::SEL_W +: kwsm_pkg::STATUS_W];
            if (results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected beat value %h source %0d status %0d",
                           $time, seen.value, seen.source, seen.status);
            end else begin
               due = results_due.pop_front();
               if (seen.value !== due.value || seen.source !== due.source ||
                   seen.status !== due.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch exp value %h source %0d status %0d, got %h %0d %0d",
                              $time, due.value, due.source, due.status,
                              seen.value, seen.source, seen.status);
               end
            end
         end
         if (csr_valid && csr_ready)
            lists_cfg = csr_data;
         if (req_tvalid && req_tready)
            results_due.insert(results_due.size(),
                               merge_step(req_tuser[kwsm_pkg::FUNC_W-1:0],
                                          req_tuser[kwsm_pkg::FUNC_W +: kwsm_pkg::SEL_W],
                                          req_tdata));
         outstanding = results_due.size();
      end
   end

endmodule

### verif/k_way_sorted_merge_core_test.sv
`timescale 1ns / 1ps
module k_way_sorted_merge_core_test;

   localparam logic [kwsm_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam logic [kwsm_pkg::CFG_W-1:0] CFG_PLAN [4] = '{4'd1, 4'd8, 4'd0, 4'd15};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [kwsm_pkg::VALUE_W-1:0]    req_tdata = '0;
   logic [kwsm_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [kwsm_pkg::VALUE_W-1:0]    rsp_tdata;
   logic [kwsm_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [kwsm_pkg::CFG_W-1:0]      csr_data = '0;

   int     mismatches;
   int     outstanding;
   int     item_count = 0;
   int     cycle_count = 0;
   bit     req_quiet = 1'b0;
   bit     rsp_quiet = 1'b0;
   bit     hold_off_armed = 1'b0;
   bit     narrow = 1'b0;
   longint run_val [kwsm_pkg::LISTS_DEF];

   always #5 clock = ~clock;

   k_way_sorted_merge_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   k_way_sorted_merge_core_checker merge_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // valid stays high across back-to-back beats
   task automatic put_req(input logic [kwsm_pkg::FUNC_W-1:0] op,
                          input logic [kwsm_pkg::SEL_W-1:0] sel,
                          input logic [kwsm_pkg::VALUE_W-1:0] val);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= val;
      req_tuser <= {sel, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op != FUNC_UNUSED)
         item_count++;
   endtask

   task automatic pop_one();
      put_req(kwsm_pkg::FUNC_POP, kwsm_pkg::SEL_W'($urandom), $urandom);
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_lists(input logic [kwsm_pkg::CFG_W-1:0] v);
      settle();
      repeat (8) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic clear_lists();
      put_req(kwsm_pkg::FUNC_CLEAR, kwsm_pkg::SEL_W'($urandom), $urandom);
      for (int i = 0; i < kwsm_pkg::LISTS_DEF; i++) begin
         if (narrow)
            run_val[i] = longint'($urandom_range(0, 2)) - 3;
         else
            case ($urandom_range(0, 3))
               0: run_val[i] = -64'sd2147483648;
               1: run_val[i] = longint'($signed($urandom));
               2: run_val[i] = longint'($urandom_range(0, 100)) - 50;
               default: run_val[i] = 64'sd2147483647 - longint'($urandom_range(0, 1000));
            endcase
      end
   endtask

   task automatic append_sorted(input int lst);
      longint nxt;
      if (narrow) begin
         nxt = run_val[lst] + longint'($urandom_range(0, 1));
         if (nxt > 3) nxt = 3;
      end else begin
         nxt = run_val[lst] + longint'($urandom_range(0, 1 << $urandom_range(0, 20)));
         if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
      end
      run_val[lst] = nxt;
      put_req(kwsm_pkg::FUNC_APPEND, kwsm_pkg::SEL_W'(lst), kwsm_pkg::VALUE_W'(nxt));
   endtask

   initial begin : stimulus
      int episode;
      int cfg_writes;
      int kind;
      int count;
      int appended;
      int popped;
      bit mix;
      int lst;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pop, unused code, extremes, tie, clear, lists in use
      pop_one();
      put_req(FUNC_UNUSED, 3'd7, 32'hffff_ffff);
      put_req(kwsm_pkg::FUNC_APPEND, 3'd0, 32'h8000_0000);
      put_req(kwsm_pkg::FUNC_APPEND, 3'd7, 32'h7fff_ffff);
      put_req(kwsm_pkg::FUNC_APPEND, 3'd3, 32'd5);
      put_req(kwsm_pkg::FUNC_APPEND, 3'd5, 32'd5);
      put_req(kwsm_pkg::FUNC_APPEND, 3'd2, 32'hffff_ffff);
      repeat (6) pop_one();
      put_req(kwsm_pkg::FUNC_APPEND, 3'd1, 32'd7);
      put_req(kwsm_pkg::FUNC_CLEAR, 3'd0, 32'd0);
      pop_one();
      write_lists(4'd1);
      put_req(kwsm_pkg::FUNC_APPEND, 3'd4, 32'd1);
      put_req(kwsm_pkg::FUNC_APPEND, 3'd0, 32'd2);
      pop_one();
      pop_one();
      write_lists(4'd0);
      pop_one();
      write_lists(4'd15);
      pop_one();

      item_count = 0;
      episode = 0;
      cfg_writes = 0;
      while (item_count < RANDOM_ITEMS) begin
         episode++;
         if (episode % 4 == 0) begin
            write_lists(cfg_writes < 4 ? CFG_PLAN[cfg_writes]
                                       : kwsm_pkg::CFG_W'($urandom_range(0, 15)));
            cfg_writes++;
         end
         req_quiet = ($urandom_range(0, 3) == 0);
         narrow = ($urandom_range(0, 2) == 0);
         kind = (episode == 1) ? 1 : $urandom_range(0, 9);
         if (kind == 0) begin
            repeat (20) put_req(kwsm_pkg::FUNC_W'($urandom_range(0, 3)),
                                kwsm_pkg::SEL_W'($urandom), $urandom);
         end else if (kind == 1) begin
            // overflow one list; first time also stalls the response side
            lst = $urandom_range(0, kwsm_pkg::LISTS_DEF - 1);
            clear_lists();
            if (episode == 1)
               hold_off_armed = 1'b1;
            repeat (kwsm_pkg::DEPTH_DEF + 2) append_sorted(lst);
            repeat (8) pop_one();
         end else begin
            if ($urandom_range(0, 4) != 0)
               clear_lists();
            count = $urandom_range(4, 40);
            mix = $urandom_range(0, 1);
            appended = 0;
            popped = 0;
            for (int j = 0; j < count; j++) begin
               if (mix && appended > popped && $urandom_range(0, 2) == 0) begin
                  pop_one();
                  popped++;
               end else begin
                  append_sorted($urandom_range(0, kwsm_pkg::LISTS_DEF - 1));
                  appended++;
               end
            end
            repeat (appended - popped + $urandom_range(0, 2)) pop_one();
         end
      end

      settle();
      repeat (40) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("k_way_sorted_merge_core_test: done, clean");
      else
         $display("k_way_sorted_merge_core_test: done, errors");
      $finish;
   end

   initial begin : sink
      int stall;
      int beats;
      beats = 0;
      forever begin
         if (beats % 50 == 0)
            rsp_quiet = ($urandom_range(0, 2) == 0);
         stall = rsp_quiet ? 0 : $urandom_range(0, 19);
         if (hold_off_armed) begin
            stall = HOLD_OFF_CYCLES;
            hold_off_armed = 1'b0;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         beats++;
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("k_way_sorted_merge_core_test: done, errors");
      $finish;
   end

endmodule

### sim.f
rtl/kwsm_pkg.sv
rtl/kwsm_ctrl.sv
rtl/kwsm_dp.sv
rtl/k_way_sorted_merge_core.sv
rtl/kwsm_checker.sv
verif/k_way_sorted_merge_core_checker.sv
verif/k_way_sorted_merge_core_test.sv
